// ===== sv/csfe_pkg.sv =====
// Package for the CAN signal field extractor: sizes, register indexes and the
// struct types shared by the front end, job queue, payload RAM, back end and top level.
// Depends on nothing.
package csfe_pkg;

    // Payload storage geometry.
    localparam int MAX_PAYLOAD_BYTES = 64;
    localparam int BYTE_IDX_W        = $clog2(MAX_PAYLOAD_BYTES);
    localparam int COUNT_W           = BYTE_IDX_W + 1;
    localparam int NUM_BANKS         = 2;
    localparam int BANK_W            = $clog2(NUM_BANKS);
    localparam int RAM_ADDR_W        = BANK_W + BYTE_IDX_W;
    localparam int RAM_DEPTH         = NUM_BANKS * MAX_PAYLOAD_BYTES;

    // Field and register widths.
    localparam int ID_W      = 29;
    localparam int START_W   = 9;
    localparam int LEN_W     = 6;
    localparam int VALUE_W   = 32;
    localparam int MAX_FIELD_BITS = 32;
    // A 32-bit field starting at bit 7 of a byte touches five bytes.
    localparam int WIN_BYTES = 5;
    localparam int WIN_W     = WIN_BYTES * 8;
    localparam int STEP_W    = 3;

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_MATCH_ID     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LSB_POS      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BIT_LENGTH   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BYTE_ORDER   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_IS_SIGNED    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_VALUE_OFFSET = 3'd5;

    localparam logic [LEN_W-1:0] BIT_LENGTH_RST = 6'd8;
    localparam logic ORDER_INTEL    = 1'b0;
    localparam logic ORDER_MOTOROLA = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0] frame_id;
        logic [7:0]      data_byte;
        logic            last_byte;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] signal_value;
        logic                      range_error;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]           match_id;
        logic [START_W-1:0]        lsb_pos;
        logic [LEN_W-1:0]          bit_length;
        logic                      byte_order;
        logic                      is_signed;
        logic signed [VALUE_W-1:0] value_offset;
    } cfg_t;

    // One extraction request: the bank that holds the frame and its byte count.
    typedef struct packed {
        logic [BANK_W-1:0]  bank;
        logic [COUNT_W-1:0] count;
    } job_t;

    // Write port of the payload RAM.
    typedef struct packed {
        logic                  en;
        logic [RAM_ADDR_W-1:0] addr;
        logic [7:0]            data;
    } ram_wr_t;

endpackage

// ===== sv/csfe_payload_ram.sv =====
// Payload RAM: two banks of frame bytes, one write port and one registered read port.
// Depends on csfe_pkg.
module csfe_payload_ram (
    input  logic                            aclk,
    input  csfe_pkg::ram_wr_t               wr,
    input  logic                            rd_en,
    input  logic [csfe_pkg::RAM_ADDR_W-1:0] rd_addr,
    output logic [7:0]                      rd_data
);
    import csfe_pkg::*;

    logic [7:0] mem [RAM_DEPTH];
    logic [7:0] rd_data_reg;

    // Byte store from the front end.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read for the back end.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/csfe_job_fifo.sv =====
// Job queue between front and back end: one entry per payload bank.
// An entry stays until the back end has finished with its bank. Depends on csfe_pkg.
module csfe_job_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  csfe_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output csfe_pkg::job_t head_job
);
    import csfe_pkg::*;

    job_t              entry_reg [NUM_BANKS];
    logic [BANK_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [BANK_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [BANK_W:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == (BANK_W + 1)'(NUM_BANKS));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + BANK_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + BANK_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + (BANK_W + 1)'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - (BANK_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== sv/csfe_front.sv =====
// Front end: accepts payload byte requests, filters on the identifier, stores
// matching bytes in the current bank and queues a job at the end of each matching frame. Depends on csfe_pkg.
module csfe_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  csfe_pkg::cfg_t     cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  csfe_pkg::in_item_t s_data,
    input  logic               job_full,
    output csfe_pkg::ram_wr_t  ram_wr,
    output logic               job_push,
    output csfe_pkg::job_t     job
);
    import csfe_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [BANK_W-1:0]  bank_reg, bank_next;
    logic               accept;
    logic               id_match;
    logic               room;
    logic [COUNT_W-1:0] stored_count;

    // The bank being filled is free whenever fewer than all banks await extraction.
    assign s_ready  = !job_full;
    assign accept   = s_valid && s_ready;
    assign id_match = (s_data.frame_id == cfg.match_id);
    assign room     = (count_reg < COUNT_W'(MAX_PAYLOAD_BYTES));
    assign stored_count = room ? count_reg + COUNT_W'(1) : count_reg;

    // Byte store; bytes past the end of the store are dropped.
    always_comb begin
        ram_wr.en   = accept && id_match && room;
        ram_wr.addr = {bank_reg, count_reg[BYTE_IDX_W-1:0]};
        ram_wr.data = s_data.data_byte;
    end

    // The final byte of a matching frame hands the bank to the back end.
    always_comb begin
        job_push  = accept && id_match && s_data.last_byte;
        job.bank  = bank_reg;
        job.count = stored_count;
    end

    // Byte count and bank selection.
    always_comb begin
        count_next = count_reg;
        bank_next  = bank_reg;
        if (accept) begin
            if (s_data.last_byte) begin
                count_next = '0;
            end else if (id_match) begin
                count_next = stored_count;
            end
        end
        if (job_push) begin
            bank_next = bank_reg + BANK_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            bank_reg  <= '0;
        end else begin
            count_reg <= count_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

// ===== sv/csfe_back.sv =====
// Back end: checks the signal against the received bytes, fetches the bytes it
// spans one per cycle, then aligns, masks, sign-extends and offsets the field. Depends on csfe_pkg.
module csfe_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  csfe_pkg::cfg_t                  cfg,
    input  logic                            head_valid,
    input  csfe_pkg::job_t                  head_job,
    output logic                            job_pop,
    output logic                            rd_en,
    output logic [csfe_pkg::RAM_ADDR_W-1:0] rd_addr,
    input  logic [7:0]                      rd_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output csfe_pkg::out_item_t             m_data
);
    import csfe_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FETCH  = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] k_reg, k_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic              err_reg, err_next;
    logic              rdv_reg;
    logic [STEP_W-1:0] rdk_reg;
    logic [WIN_W-1:0]  win_reg;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg;

    logic [LEN_W-1:0]      len;
    logic                  len_zero;
    logic [BYTE_IDX_W-1:0] first_byte;
    logic [2:0]            first_bit;
    logic [LEN_W-1:0]      span;
    logic [STEP_W-1:0]     steps;
    logic [COUNT_W-1:0]    intel_last;
    logic                  err_intel;
    logic                  err_moto;
    logic                  range_err;
    logic [BYTE_IDX_W-1:0] byte_idx;
    logic                  out_free;
    logic                  load;
    logic [WIN_W-1:0]      shifted;
    logic [VALUE_W-1:0]    field;
    logic [VALUE_W-1:0]    mask;
    logic [VALUE_W-1:0]    raw;
    logic [4:0]            sign_idx;
    out_item_t             result;

    // Signal geometry; lengths above the maximum are clipped.
    assign len        = (cfg.bit_length > LEN_W'(MAX_FIELD_BITS)) ?
                        LEN_W'(MAX_FIELD_BITS) : cfg.bit_length;
    assign len_zero   = (len == '0);
    assign first_byte = cfg.lsb_pos[START_W-1:3];
    assign first_bit  = cfg.lsb_pos[2:0];
    assign span       = LEN_W'({3'b000, first_bit}) + len - LEN_W'(1);
    assign steps      = span[LEN_W-1:3];

    // Range check against the byte count of the frame at the head of the queue.
    assign intel_last = COUNT_W'(first_byte) + COUNT_W'(steps);
    assign err_intel  = (intel_last >= head_job.count);
    assign err_moto   = (BYTE_IDX_W'(steps) > first_byte) ||
                        (COUNT_W'(first_byte) >= head_job.count);
    assign range_err  = !len_zero &&
                        ((cfg.byte_order == ORDER_MOTOROLA) ? err_moto : err_intel);

    // Byte fetch address: walk up for Intel order, down for Motorola.
    assign byte_idx = (cfg.byte_order == ORDER_MOTOROLA) ?
                      first_byte - BYTE_IDX_W'(k_reg) : first_byte + BYTE_IDX_W'(k_reg);
    assign rd_en    = (state_reg == ST_FETCH);
    assign rd_addr  = {head_job.bank, byte_idx};

    assign out_free = !out_valid_reg || m_ready;
    assign load     = (state_reg == ST_FINISH) && out_free;
    assign job_pop  = load;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        steps_next = steps_reg;
        err_next   = err_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    k_next     = '0;
                    steps_next = steps;
                    err_next   = range_err;
                    state_next = (range_err || len_zero) ? ST_FINISH : ST_FETCH;
                end
            end
            ST_FETCH: begin
                k_next = k_reg + STEP_W'(1);
                if (k_reg == steps_reg) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rdv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            rdv_reg   <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg     <= k_next;
        steps_reg <= steps_next;
        err_reg   <= err_next;
        rdk_reg   <= k_reg;
    end

    // Each fetched byte lands in its lane of the window.
    always_ff @(posedge aclk) begin
        if (rdv_reg) begin
            win_reg[rdk_reg * 8 +: 8] <= rd_data;
        end
    end

    // Field alignment, masking, sign extension and offset.
    always_comb begin
        shifted  = win_reg >> first_bit;
        field    = shifted[VALUE_W-1:0];
        mask     = ~({VALUE_W{1'b1}} << len);
        raw      = field & mask;
        sign_idx = 5'(len - LEN_W'(1));
        if (cfg.is_signed && !len_zero && field[sign_idx]) begin
            raw = raw | ~mask;
        end
        if (err_reg) begin
            result.signal_value = '0;
            result.range_error  = 1'b1;
        end else begin
            result.signal_value = $signed(raw + $unsigned(cfg.value_offset));
            result.range_error  = 1'b0;
        end
    end

    // Output register parts the back end from the result channel.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // A job in progress always has its entry at the head of the queue.
    a_busy_has_job: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> head_valid)
        else $error("back end busy without a queued job");

    // The fetch never runs past the last byte the signal spans.
    a_fetch_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FETCH |-> k_reg <= steps_reg && steps_reg < STEP_W'(WIN_BYTES))
        else $error("byte fetch beyond signal span");

    // A finished job reaches the output register in the next cycle.
    a_finish_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH && out_free |=> out_valid_reg)
        else $error("finished job not delivered");

    // An out-of-range result carries a zero value.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.range_error |-> out_data_reg.signal_value == '0)
        else $error("range error with non-zero value");

endmodule

// ===== sv/can_signal_field_extractor.sv =====
// CAN signal field extractor. The final byte request of a matching frame queues a job; for
// an out-of-range or zero-length signal the back end goes straight to its finish state, else
// it reads the one to five bytes the signal spans (one RAM read each) and waits for the last.
// Throughput: one byte request per cycle while fewer than two frames await extraction; the
// back end works on one frame at a time. Reset is synchronous, active low; it clears counters,
// queue and configuration (bit length 8, others 0); no RAM clearing.
module can_signal_field_extractor (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [csfe_pkg::PADDR_W-1:0] paddr,
    input  logic [csfe_pkg::PDATA_W-1:0] pwdata,
    output logic [csfe_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  csfe_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output csfe_pkg::out_item_t          m_data
);
    import csfe_pkg::*;

    cfg_t                  cfg_reg;
    logic                  cfg_write;
    logic [REG_IDX_W-1:0]  reg_idx;
    ram_wr_t               ram_wr;
    logic                  job_push;
    job_t                  push_job;
    logic                  job_pop;
    logic                  job_full;
    logic                  head_valid;
    job_t                  head_job;
    logic                  rd_en;
    logic [RAM_ADDR_W-1:0] rd_addr;
    logic [7:0]            rd_data;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.match_id     <= '0;
            cfg_reg.lsb_pos      <= '0;
            cfg_reg.bit_length   <= BIT_LENGTH_RST;
            cfg_reg.byte_order   <= ORDER_INTEL;
            cfg_reg.is_signed    <= 1'b0;
            cfg_reg.value_offset <= '0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_MATCH_ID:     cfg_reg.match_id     <= pwdata[ID_W-1:0];
                REG_LSB_POS:      cfg_reg.lsb_pos      <= pwdata[START_W-1:0];
                REG_BIT_LENGTH:   cfg_reg.bit_length   <= pwdata[LEN_W-1:0];
                REG_BYTE_ORDER:   cfg_reg.byte_order   <= pwdata[0];
                REG_IS_SIGNED:    cfg_reg.is_signed    <= pwdata[0];
                REG_VALUE_OFFSET: cfg_reg.value_offset <= $signed(pwdata[VALUE_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_idx)
            REG_MATCH_ID:     prdata = PDATA_W'(cfg_reg.match_id);
            REG_LSB_POS:      prdata = PDATA_W'(cfg_reg.lsb_pos);
            REG_BIT_LENGTH:   prdata = PDATA_W'(cfg_reg.bit_length);
            REG_BYTE_ORDER:   prdata = PDATA_W'(cfg_reg.byte_order);
            REG_IS_SIGNED:    prdata = PDATA_W'(cfg_reg.is_signed);
            REG_VALUE_OFFSET: prdata = PDATA_W'($unsigned(cfg_reg.value_offset));
            default:          prdata = '0;
        endcase
    end

    csfe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .job_full (job_full),
        .ram_wr   (ram_wr),
        .job_push (job_push),
        .job      (push_job)
    );

    csfe_payload_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    csfe_job_fifo u_jobs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_push),
        .push_job   (push_job),
        .pop        (job_pop),
        .full       (job_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    csfe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .job_pop    (job_pop),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== tb/sv/csfe_scoreboard_pkg.sv =====
// Scoreboard for the CAN signal field extractor testbench: a copy of the register
// set and payload buffer, the signal decoder and the queue of decoded values due.
// Depends on csfe_pkg for the request, result and register types.
package csfe_scoreboard_pkg;
    import csfe_pkg::*;

    class signal_scoreboard;
        cfg_t        settings;
        logic [7:0]  frame_bytes [MAX_PAYLOAD_BYTES];
        int unsigned bytes_held;
        out_item_t   pending_values [$];
        int unsigned fail_count;

        // State after reset: bit length 8, every other register zero, no bytes held.
        function new();
            settings            = '0;
            settings.bit_length = BIT_LENGTH_RST;
            bytes_held          = 0;
            fail_count          = 0;
        endfunction

        // Mirror a register write on the configuration port.
        function void write_reg(input logic [REG_IDX_W-1:0] idx,
                                input logic [PDATA_W-1:0] val);
            case (idx)
                REG_MATCH_ID:     settings.match_id     = val[ID_W-1:0];
                REG_LSB_POS:      settings.lsb_pos      = val[START_W-1:0];
                REG_BIT_LENGTH:   settings.bit_length   = val[LEN_W-1:0];
                REG_BYTE_ORDER:   settings.byte_order   = val[0];
                REG_IS_SIGNED:    settings.is_signed    = val[0];
                REG_VALUE_OFFSET: settings.value_offset = val;
                default: ;
            endcase
        endfunction

        // Walk the signal bits through the held bytes and form the decoded value.
        // Any bit below byte 0 or beyond the bytes held gives a range error.
        function out_item_t decode_signal();
            out_item_t   res;
            int unsigned len;
            int unsigned first_byte;
            int unsigned first_bit;
            int unsigned pos;
            int unsigned hop;
            int unsigned idx;
            logic [31:0] acc;
            res.signal_value = '0;
            res.range_error  = 1'b1;
            len        = (settings.bit_length > MAX_FIELD_BITS) ? MAX_FIELD_BITS
                                                                : settings.bit_length;
            first_byte = settings.lsb_pos >> 3;
            first_bit  = settings.lsb_pos & 7;
            acc        = '0;
            for (int unsigned i = 0; i < len; i++) begin
                pos = first_bit + i;
                hop = pos >> 3;
                if (settings.byte_order == ORDER_MOTOROLA) begin
                    if (hop > first_byte)
                        return res;
                    idx = first_byte - hop;
                end else begin
                    idx = first_byte + hop;
                end
                if (idx >= bytes_held || idx >= MAX_PAYLOAD_BYTES)
                    return res;
                acc[i] = frame_bytes[idx][pos & 7];
            end
            // Two's complement sign extension; a full 32-bit field needs none.
            if (settings.is_signed && len >= 1 && len < 32 && acc[len-1])
                acc = acc | ~((32'd1 << len) - 32'd1);
            res.signal_value = acc + settings.value_offset;
            res.range_error  = 1'b0;
            return res;
        endfunction

        // An accepted byte request: drop foreign bytes, store matching ones and
        // decode the signal when the final byte of a matching frame arrives.
        function void note_request(input in_item_t req);
            if (req.frame_id != settings.match_id) begin
                if (req.last_byte)
                    bytes_held = 0;
                return;
            end
            // Bytes beyond the buffer are dropped and the count saturates.
            if (bytes_held < MAX_PAYLOAD_BYTES) begin
                frame_bytes[bytes_held] = req.data_byte;
                bytes_held++;
            end
            if (!req.last_byte)
                return;
            pending_values.push_back(decode_signal());
            bytes_held = 0;
        endfunction

        function int unsigned pending_count();
            return pending_values.size();
        endfunction

        task report(input string what);
            if (fail_count < 40)
                $display("mismatch: %s", what);
            fail_count++;
        endtask

        // Compare one accepted result with the oldest decoded value due.
        task check_result(input out_item_t got);
            out_item_t want;
            if (pending_values.size() == 0) begin
                report($sformatf("result with nothing due: value %0d range_error %0b",
                                 got.signal_value, got.range_error));
                return;
            end
            want = pending_values.pop_front();
            if (got.signal_value !== want.signal_value)
                report($sformatf("signal_value %0d, due %0d",
                                 got.signal_value, want.signal_value));
            if (got.range_error !== want.range_error)
                report($sformatf("range_error %0b, due %0b",
                                 got.range_error, want.range_error));
        endtask
    endclass

endpackage

// ===== tb/sv/tb.sv =====
// Top-level testbench for the CAN signal field extractor: drives payload bytes and
// register writes, stalls the result side and checks every decoded value.
// Depends on csfe_pkg, csfe_scoreboard_pkg and the can_signal_field_extractor RTL.
module tb;
    import csfe_pkg::*;
    import csfe_scoreboard_pkg::*;

    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_CYCLES     = 300;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_item_t           s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_item_t          m_data;

    signal_scoreboard sb = new();

    // Sender state and the register values currently loaded.
    int unsigned burst_left  = 0;
    int unsigned phase_items = 0;
    cfg_t        active_cfg;

    can_signal_field_extractor DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Hard limit on the run.
    initial begin
        #4000000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic in_item_t make_req(input logic [ID_W-1:0] id,
                                          input logic [7:0] data, input logic last);
        in_item_t req;
        req.frame_id  = id;
        req.data_byte = data;
        req.last_byte = last;
        return req;
    endfunction

    // Offer one byte request, opening a new burst after a random gap when the
    // current one is used up, and wait for it to be accepted.
    task automatic send_req(input in_item_t req);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        sb.note_request(req);
    endtask

    // Register write: setup, access until pready, then idle; the scoreboard copy follows.
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic load_config(input cfg_t c);
        apb_write(REG_MATCH_ID, 32'(c.match_id));
        apb_write(REG_LSB_POS, 32'(c.lsb_pos));
        apb_write(REG_BIT_LENGTH, 32'(c.bit_length));
        apb_write(REG_BYTE_ORDER, 32'(c.byte_order));
        apb_write(REG_IS_SIGNED, 32'(c.is_signed));
        apb_write(REG_VALUE_OFFSET, c.value_offset);
        active_cfg = c;
    endtask

    // Stop offering requests, wait for every decoded value due and let the
    // back end run dry before the registers are touched again.
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic cfg_t make_cfg(input logic [ID_W-1:0] id, input int unsigned sbit,
                                      input int unsigned len, input logic order,
                                      input logic sgn, input logic [31:0] offset);
        cfg_t c;
        c.match_id     = id;
        c.lsb_pos      = START_W'(sbit);
        c.bit_length   = LEN_W'(len);
        c.byte_order   = order;
        c.is_signed    = sgn;
        c.value_offset = offset;
        return c;
    endfunction

    // Register set for one random phase; some phases pin a field to an extreme.
    function automatic cfg_t pick_config(input int phase);
        cfg_t c;
        c.match_id = (phase % 4 == 0) ? '0 : (phase % 4 == 1) ? '1 : ID_W'($urandom);
        c.byte_order = 1'($urandom_range(0, 1));
        c.is_signed  = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
            c.lsb_pos = START_W'($urandom_range(0, 15));
        else
            c.lsb_pos = START_W'($urandom_range(0, 63));
        // Signal at the very top of a full CAN FD payload, read downwards.
        if (phase == 3) begin
            c.lsb_pos    = START_W'(511);
            c.byte_order = ORDER_MOTOROLA;
        end
        if (phase == 8)
            c.lsb_pos = START_W'($urandom_range(256, 511));
        case (phase % 5)
            0: c.bit_length = LEN_W'(32);
            1: c.bit_length = LEN_W'(1);
            default: begin
                if ($urandom_range(0, 7) == 0)
                    c.bit_length = LEN_W'(($urandom_range(0, 2) == 0) ? 0
                                                                      : $urandom_range(33, 63));
                else
                    c.bit_length = LEN_W'($urandom_range(1, 32));
            end
        endcase
        case (phase)
            2:       c.value_offset = 32'h7FFF_FFFF;
            5:       c.value_offset = 32'h8000_0000;
            6:       c.value_offset = '0;
            default: c.value_offset = $urandom;
        endcase
        return c;
    endfunction

    // One frame: mostly matching frames sized around the loaded signal, some short
    // or overlong, some foreign, some with a foreign byte inside or no final marker.
    task automatic send_frame();
        int unsigned need;
        int unsigned lo;
        int unsigned hi;
        int unsigned nbytes;
        int unsigned noise_at;
        logic        foreign;
        logic        broken;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] other_id;
        need = (active_cfg.lsb_pos >> 3) + 1 +
               ((active_cfg.byte_order == ORDER_INTEL) ? 4 : 0);
        if (need > 70)
            need = 70;
        lo = (need > 3) ? need - 3 : 1;
        hi = (need + 1 > 70) ? 70 : need + 1;
        case ($urandom_range(0, 19))
            12, 13, 14, 15, 16: nbytes = $urandom_range(1, 8);
            17, 18:             nbytes = $urandom_range(9, 64);
            19:                 nbytes = $urandom_range(65, 70);
            default:            nbytes = $urandom_range(lo, hi);
        endcase
        other_id = active_cfg.match_id ^ (ID_W'(1) << $urandom_range(0, ID_W - 1));
        foreign  = ($urandom_range(0, 14) == 0);
        broken   = ($urandom_range(0, 19) == 0);
        noise_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, nbytes - 1) : nbytes;
        id       = foreign ? other_id : active_cfg.match_id;
        for (int unsigned k = 0; k < nbytes; k++) begin
            if (k == noise_at)
                send_req(make_req(other_id, 8'($urandom), 1'($urandom_range(0, 1))));
            send_req(make_req(id, 8'($urandom), (k == nbytes - 1) && !broken));
            if (!foreign)
                phase_items++;
        end
    endtask

    // Result side: checks each accepted result and stalls on a pattern picked at random,
    // with two long hold-offs that back up the block.
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned cyc;
        int unsigned mode;
        int unsigned seen;
        hold_left = 0;
        cyc       = 0;
        mode      = 0;
        seen      = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_result(m_data);
                seen++;
                if (seen == 20 || seen == 90)
                    hold_left = HOLD_CYCLES;
            end
            cyc++;
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= (cyc % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Main sequence: reset, directed frames, then random phases.
    initial begin : stimulus
        cfg_t c;
        active_cfg            = '0;
        active_cfg.bit_length = BIT_LENGTH_RST;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers at their reset values: first byte decoded, foreign frame dropped.
        send_req(make_req('0, 8'hFF, 1'b0));
        send_req(make_req('0, 8'h00, 1'b1));
        send_req(make_req('1, 8'hA5, 1'b0));
        send_req(make_req('1, 8'h5A, 1'b1));
        send_req(make_req('0, 8'h80, 1'b1));
        settle();

        // Full-length signed field with the largest positive offset; then a short frame.
        load_config(make_cfg('1, 0, 32, ORDER_INTEL, 1'b1, 32'h7FFF_FFFF));
        send_req(make_req('1, 8'h00, 1'b0));
        send_req(make_req('1, 8'h00, 1'b0));
        send_req(make_req('1, 8'h00, 1'b0));
        send_req(make_req('1, 8'h80, 1'b1));
        send_req(make_req('1, 8'hFF, 1'b0));
        send_req(make_req('1, 8'hFF, 1'b0));
        send_req(make_req('1, 8'hFF, 1'b1));
        settle();

        // Motorola order across two bytes, then the same signal past the frame end.
        load_config(make_cfg(29'h0123_4567, 8, 16, ORDER_MOTOROLA, 1'b1, 32'h8000_0000));
        send_req(make_req(29'h0123_4567, 8'h01, 1'b0));
        send_req(make_req(29'h0123_4567, 8'hFF, 1'b1));
        send_req(make_req(29'h0123_4567, 8'hC3, 1'b1));
        settle();

        // Zero length: the result is the offset even with the start out of reach.
        load_config(make_cfg(29'h0ABC_DEF0, 511, 0, ORDER_INTEL, 1'b1, 32'h1234_5678));
        send_req(make_req(29'h0ABC_DEF0, 8'h77, 1'b1));
        settle();

        // A length above 32 is clipped to 32 bits.
        load_config(make_cfg(29'h00F0_F0F0, 7, 63, ORDER_INTEL, 1'b0, '0));
        for (int k = 0; k < 5; k++)
            send_req(make_req(29'h00F0_F0F0, 8'hFF, k == 4));
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            c = pick_config(phase);
            load_config(c);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
                send_frame();
            settle();
        end

        if (sb.fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== can_signal_field_extractor.f =====
sv/csfe_pkg.sv
sv/csfe_payload_ram.sv
sv/csfe_job_fifo.sv
sv/csfe_front.sv
sv/csfe_back.sv
sv/can_signal_field_extractor.sv
tb/sv/csfe_scoreboard_pkg.sv
tb/sv/tb.sv
